// File: hdl/srs_pkg.sv
// shared types, constants and helpers of the sparse coefficient row store
package srs_pkg;

  localparam int SLOTS   = 64;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int KEY_W   = 16;
  localparam int COEFF_W = 32;
  localparam int EPS_W   = 16;

  localparam logic [2:0] KIND_PUT    = 3'd0;
  localparam logic [2:0] KIND_ADD    = 3'd1;
  localparam logic [2:0] KIND_REMOVE = 3'd2;
  localparam logic [2:0] KIND_GET    = 3'd3;
  localparam logic [2:0] KIND_NEGATE = 3'd4;
  localparam logic [2:0] KIND_DIVIDE = 3'd5;
  localparam logic [2:0] KIND_CLEAR  = 3'd6;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ABSENT  = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_DIVZERO = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic signed [COEFF_W-1:0] coeff;
  } entry_t;

  // magnitude strictly below epsilon
  function automatic logic near_zero(input logic signed [COEFF_W:0] x,
                                     input logic [EPS_W-1:0] eps);
    logic signed [COEFF_W+1:0] xw;
    logic signed [COEFF_W+1:0] ew;
    begin
      xw = (COEFF_W+2)'(x);
      ew = (COEFF_W+2)'({1'b0, eps});
      near_zero = (xw > -ew) && (xw < ew);
    end
  endfunction

  function automatic logic signed [COEFF_W-1:0] sat32(input logic signed [COEFF_W:0] x);
    logic signed [COEFF_W:0] hi;
    logic signed [COEFF_W:0] lo;
    begin
      hi = (COEFF_W+1)'({2'b00, {(COEFF_W-1){1'b1}}});
      lo = (COEFF_W+1)'({2'b11, {(COEFF_W-1){1'b0}}});
      if (x > hi) sat32 = hi[COEFF_W-1:0];
      else if (x < lo) sat32 = lo[COEFF_W-1:0];
      else sat32 = x[COEFF_W-1:0];
    end
  endfunction

endpackage

// File: hdl/srs_slot_ram.sv
// slot memory: key and coefficient per slot, one write and one registered read port
module srs_slot_ram
  import srs_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/srs_divider.sv
// iterative signed divider, one quotient bit per cycle, saturated 32 bit result
module srs_divider
  import srs_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [COEFF_W+15:0] dividend,
  input  logic signed [COEFF_W-1:0]  divisor,
  output logic                       done,
  output logic signed [COEFF_W-1:0]  quotient
);

  localparam int NUM_W = COEFF_W + 16;
  localparam int CYC_W = $clog2(NUM_W);

  logic             running;
  logic [CYC_W-1:0] cnt;
  logic [NUM_W-1:0] num;
  logic [COEFF_W-1:0] den;
  logic [COEFF_W-1:0] rem;
  logic             neg;
  logic [COEFF_W:0] rem_sh;
  logic             ge;
  logic [NUM_W-1:0] q_fin;
  logic signed [COEFF_W-1:0] q_sat;

  assign rem_sh = {rem, num[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den};
  assign q_fin  = {num[NUM_W-2:0], ge};

  // magnitude to signed with saturation
  always_comb begin
    if (!neg) begin
      if (q_fin > NUM_W'({1'b0, {(COEFF_W-1){1'b1}}})) q_sat = {1'b0, {(COEFF_W-1){1'b1}}};
      else q_sat = q_fin[COEFF_W-1:0];
    end else begin
      if (q_fin > NUM_W'({1'b1, {(COEFF_W-1){1'b0}}})) q_sat = {1'b1, {(COEFF_W-1){1'b0}}};
      else q_sat = -q_fin[COEFF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
        rem     <= '0;
        neg     <= dividend[NUM_W-1] ^ divisor[COEFF_W-1];
        num     <= dividend[NUM_W-1] ? NUM_W'(-dividend) : NUM_W'(dividend);
        den     <= divisor[COEFF_W-1] ? COEFF_W'(-divisor) : COEFF_W'(divisor);
      end else if (running) begin
        rem <= ge ? COEFF_W'(rem_sh - {1'b0, den}) : rem_sh[COEFF_W-1:0];
        num <= q_fin;
        cnt <= cnt + 1'b1;
        if (cnt == CYC_W'(NUM_W - 1)) begin
          running  <= 1'b0;
          done     <= 1'b1;
          quotient <= q_sat;
        end
      end
    end
  end

endmodule

// File: hdl/sparse_coefficient_row_store.sv
// top level of the sparse coefficient row store: command sequencer and slot bookkeeping
//
// Holds up to 64 Q16.16 coefficients keyed by a 16 bit variable id. A command
// is taken when start is high and busy is low; exactly one result beat follows,
// marked by a one-cycle done strobe, and it cannot be held off. Put, add,
// remove and get scan the slot memory one slot per cycle, through all 64
// slots when the id is absent and up to its slot when present. Negate-all
// walks all 64 slots, skips empty ones in S_SWRD and rewrites each live entry
// via S_SWDATA; divide-all also waits in S_SWDIV for the 48-step bit-serial
// divider per live entry. Clear, add of an operand inside epsilon, divide by
// zero and the unused kind go straight to S_FINISH. The result beat comes in
// the same cycle as busy drops. The slot memory needs no clearing pass after
// reset: per-slot valid flops mark live entries.
// epsilon may only be written while busy is low and no result is pending.
module sparse_coefficient_row_store
  import srs_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                kind,
  input  logic [KEY_W-1:0]          var_id,
  input  logic signed [COEFF_W-1:0] operand_value,
  input  logic                      epsilon_wr,
  input  logic [EPS_W-1:0]          epsilon,
  output logic                      done,
  output logic signed [COEFF_W-1:0] value_out,
  output logic [1:0]                status,
  output logic [CNT_W-1:0]          entry_total
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SCAN   = 8'b0000_0010,
    S_HIT    = 8'b0000_0100,
    S_MISS   = 8'b0000_1000,
    S_SWRD   = 8'b0001_0000,
    S_SWDATA = 8'b0010_0000,
    S_SWDIV  = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_t;

  state_t state;

  // command beat latched at acceptance; eps holds the current epsilon
  logic [2:0]                op_kind;
  logic [KEY_W-1:0]          op_key;
  logic signed [COEFF_W-1:0] op_val;
  logic [EPS_W-1:0]          eps;

  logic [SLOTS-1:0]          valid;
  logic [CNT_W-1:0]          count;

  // scan pointers: idx issues reads, chk_idx is the slot whose data is back
  logic [IDX_W:0]            idx;
  logic                      chk_live;
  logic [IDX_W-1:0]          chk_idx;
  logic                      free_found;
  logic [IDX_W-1:0]          free_idx;
  logic [IDX_W-1:0]          hit_idx;
  logic signed [COEFF_W-1:0] hit_coeff;

  logic signed [COEFF_W-1:0] res_value;
  logic [1:0]                res_status;

  logic                      rd_en;
  entry_t                    rd_data;
  logic                      wr_en;
  logic [IDX_W-1:0]          wr_addr;
  entry_t                    wr_data;

  logic                      div_start;
  logic                      div_done;
  logic signed [COEFF_W-1:0] div_q;

  logic                      opv_nz;
  logic signed [COEFF_W-1:0] sum;
  logic                      sum_nz;
  logic signed [COEFF_W-1:0] neg_coeff;
  logic                      at_end;

  assign busy      = (state != S_IDLE);
  assign opv_nz    = near_zero((COEFF_W+1)'(op_val), eps);
  assign sum       = sat32((COEFF_W+1)'(hit_coeff) + (COEFF_W+1)'(op_val));
  assign sum_nz    = near_zero((COEFF_W+1)'(sum), eps);
  assign neg_coeff = sat32(-((COEFF_W+1)'(rd_data.coeff)));
  assign at_end    = (idx == (IDX_W+1)'(SLOTS));

  assign rd_en = ((state == S_SCAN) && !at_end) ||
                 ((state == S_SWRD) && !at_end && valid[idx[IDX_W-1:0]]);
  assign div_start = (state == S_SWDATA) && (op_kind == KIND_DIVIDE);

  srs_slot_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  srs_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({rd_data.coeff, 16'h0000}),
    .divisor  (op_val),
    .done     (div_done),
    .quotient (div_q)
  );

  // write port of the slot memory
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx[IDX_W-1:0];
    wr_data = '{key: op_key, coeff: op_val};
    case (state)
      S_HIT: begin
        wr_addr = hit_idx;
        if (op_kind == KIND_PUT && !opv_nz) begin
          wr_en = 1'b1;
        end else if (op_kind == KIND_ADD && !sum_nz) begin
          wr_en   = 1'b1;
          wr_data = '{key: op_key, coeff: sum};
        end
      end
      S_MISS: begin
        wr_addr = free_idx;
        wr_en   = (op_kind == KIND_PUT || op_kind == KIND_ADD) && !opv_nz && free_found;
      end
      S_SWDATA: begin
        wr_en   = (op_kind == KIND_NEGATE);
        wr_data = '{key: rd_data.key, coeff: neg_coeff};
      end
      S_SWDIV: begin
        wr_en   = div_done;
        wr_data = '{key: rd_data.key, coeff: div_q};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      eps        <= EPS_W'(66);
      valid      <= '0;
      count      <= '0;
      done       <= 1'b0;
      chk_live   <= 1'b0;
      free_found <= 1'b0;
    end else begin
      done <= 1'b0;
      if (epsilon_wr) begin
        eps <= epsilon;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            op_kind    <= kind;
            op_key     <= var_id;
            op_val     <= operand_value;
            res_value  <= '0;
            res_status <= ST_OK;
            idx        <= '0;
            chk_live   <= 1'b0;
            free_found <= 1'b0;
            case (kind)
              KIND_PUT, KIND_REMOVE, KIND_GET: state <= S_SCAN;
              KIND_ADD: begin
                // an operand inside epsilon is a no-op
                if (near_zero((COEFF_W+1)'(operand_value), eps)) state <= S_FINISH;
                else state <= S_SCAN;
              end
              KIND_NEGATE: state <= S_SWRD;
              KIND_DIVIDE: begin
                if (operand_value == '0) begin
                  res_status <= ST_DIVZERO;
                  state      <= S_FINISH;
                end else begin
                  state <= S_SWRD;
                end
              end
              KIND_CLEAR: begin
                valid <= '0;
                count <= '0;
                state <= S_FINISH;
              end
              default: state <= S_FINISH;
            endcase
          end
        end
        S_SCAN: begin
          if (!at_end) begin
            idx      <= idx + 1'b1;
            chk_live <= 1'b1;
            chk_idx  <= idx[IDX_W-1:0];
          end else begin
            chk_live <= 1'b0;
          end
          if (chk_live) begin
            if (valid[chk_idx] && rd_data.key == op_key) begin
              hit_idx   <= chk_idx;
              hit_coeff <= rd_data.coeff;
              state     <= S_HIT;
            end else begin
              // remember the lowest free slot for a later insert
              if (!valid[chk_idx] && !free_found) begin
                free_found <= 1'b1;
                free_idx   <= chk_idx;
              end
              if (chk_idx == IDX_W'(SLOTS - 1)) state <= S_MISS;
            end
          end
        end
        S_HIT: begin
          case (op_kind)
            KIND_PUT: begin
              if (opv_nz) begin
                valid[hit_idx] <= 1'b0;
                count          <= count - 1'b1;
              end
            end
            KIND_ADD: begin
              if (sum_nz) begin
                valid[hit_idx] <= 1'b0;
                count          <= count - 1'b1;
              end
            end
            KIND_REMOVE: begin
              res_value      <= hit_coeff;
              valid[hit_idx] <= 1'b0;
              count          <= count - 1'b1;
            end
            KIND_GET: res_value <= hit_coeff;
            default: res_value <= '0;
          endcase
          state <= S_FINISH;
        end
        S_MISS: begin
          if (op_kind == KIND_PUT || op_kind == KIND_ADD) begin
            if (!opv_nz) begin
              if (free_found) begin
                valid[free_idx] <= 1'b1;
                count           <= count + 1'b1;
              end else begin
                res_status <= ST_FULL;
              end
            end
          end else begin
            res_status <= ST_ABSENT;
          end
          state <= S_FINISH;
        end
        S_SWRD: begin
          if (at_end) begin
            state <= S_FINISH;
          end else if (valid[idx[IDX_W-1:0]]) begin
            state <= S_SWDATA;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_SWDATA: begin
          if (op_kind == KIND_NEGATE) begin
            idx   <= idx + 1'b1;
            state <= S_SWRD;
          end else begin
            state <= S_SWDIV;
          end
        end
        S_SWDIV: begin
          if (div_done) begin
            idx   <= idx + 1'b1;
            state <= S_SWRD;
          end
        end
        S_FINISH: begin
          done        <= 1'b1;
          value_out   <= res_value;
          status      <= res_status;
          entry_total <= count;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result beat only goes out once the block is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while busy");

  // an accepted command always occupies the block
  a_accept_busy: assert property (@(posedge clk) disable iff (rst) start && !busy |=> busy)
    else $error("command accepted but block not busy");

  // live count never passes the slot count
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(SLOTS))
    else $error("live count out of range");

  // a refused insert only happens with every slot in use
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_FULL |-> entry_total == CNT_W'(SLOTS))
    else $error("table full reported with free slots");

endmodule

// File: tb/sv/sparse_coefficient_row_store_test.sv
// testbench for the sparse coefficient row store: random and directed commands against a predictor
`timescale 1ns / 100ps

module sparse_coefficient_row_store_test
  import srs_pkg::*;
();

  localparam int ROW_CAP = 64;
  localparam int WATCHDOG_LIMIT = 20000;
  // kind code with no operation behind it
  localparam logic [2:0] KIND_NONE = 3'd7;

  // expected result of one command
  typedef struct {
    logic signed [31:0] value;
    logic [1:0]         stat;
    logic [6:0]         total;
  } row_result_t;

  // predictor of the row: keeps entries as (id, coeff) per slot, lowest free slot first
  class row_scoreboard;
    bit                 used[ROW_CAP];
    logic [15:0]        ids[ROW_CAP];
    logic signed [31:0] coeffs[ROW_CAP];
    int                 live;
    logic [15:0]        eps;
    row_result_t        pending[$];
    int                 mismatches;
    int                 checked;

    function void clear_row();
      for (int i = 0; i < ROW_CAP; i++) used[i] = 0;
      live = 0;
    endfunction

    function bit small_mag(longint x);
      return (x > -longint'(eps)) && (x < longint'(eps));
    endfunction

    function logic signed [31:0] clamp(longint x);
      if (x > 64'sd2147483647) return 32'sh7fffffff;
      if (x < -64'sd2147483648) return 32'sh80000000;
      return x[31:0];
    endfunction

    function int find_id(logic [15:0] id);
      for (int i = 0; i < ROW_CAP; i++)
        if (used[i] && ids[i] == id) return i;
      return -1;
    endfunction

    function logic [1:0] store_value(logic [15:0] id, logic signed [31:0] v);
      int s;
      s = find_id(id);
      if (small_mag(v)) begin
        if (s >= 0) begin
          used[s] = 0;
          live--;
        end
        return ST_OK;
      end
      if (s >= 0) begin
        coeffs[s] = v;
        return ST_OK;
      end
      for (int i = 0; i < ROW_CAP; i++)
        if (!used[i]) begin
          used[i] = 1;
          ids[i] = id;
          coeffs[i] = v;
          live++;
          return ST_OK;
        end
      return ST_FULL;
    endfunction

    // note one accepted command and queue its expected result
    function void note_command(logic [2:0] k, logic [15:0] id, logic signed [31:0] v);
      row_result_t r;
      int s;
      longint q;
      r.value = 0;
      r.stat = ST_OK;
      case (k)
        KIND_PUT: r.stat = store_value(id, v);
        KIND_ADD: begin
          if (!small_mag(v)) begin
            s = find_id(id);
            if (s < 0) r.stat = store_value(id, v);
            else begin
              coeffs[s] = clamp(longint'(coeffs[s]) + longint'(v));
              if (small_mag(coeffs[s])) begin
                used[s] = 0;
                live--;
              end
            end
          end
        end
        KIND_REMOVE, KIND_GET: begin
          s = find_id(id);
          if (s < 0) r.stat = ST_ABSENT;
          else begin
            r.value = coeffs[s];
            if (k == KIND_REMOVE) begin
              used[s] = 0;
              live--;
            end
          end
        end
        KIND_NEGATE:
          for (int i = 0; i < ROW_CAP; i++)
            if (used[i]) coeffs[i] = clamp(-longint'(coeffs[i]));
        KIND_DIVIDE: begin
          if (v == 0) r.stat = ST_DIVZERO;
          else
            for (int i = 0; i < ROW_CAP; i++)
              if (used[i]) begin
                q = (longint'(coeffs[i]) * 65536) / longint'(v);
                coeffs[i] = clamp(q);
              end
        end
        KIND_CLEAR: clear_row();
        default: ;
      endcase
      r.total = live[6:0];
      pending.push_back(r);
    endfunction

    // compare one result beat with the oldest expectation
    function void check_result(logic signed [31:0] v, logic [1:0] st, logic [6:0] tot);
      row_result_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat value %0d status %0d", v, st);
        return;
      end
      e = pending.pop_front();
      if (v !== e.value || st !== e.stat || tot !== e.total) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected value %0d status %0d total %0d, got %0d %0d %0d",
                   e.value, e.stat, e.total, v, st, tot);
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               start = 0;
  logic               busy;
  logic [2:0]         kind = 0;
  logic [15:0]        var_id = 0;
  logic signed [31:0] operand_value = 0;
  logic               epsilon_wr = 0;
  logic [15:0]        epsilon = 0;
  logic               done;
  logic signed [31:0] value_out;
  logic [1:0]         status;
  logic [CNT_W-1:0]   entry_total;

  row_scoreboard sb;
  int idle_pct;
  int quiet_cycles;
  int sent;
  bit timed_out;

  always #5 clk = ~clk;

  sparse_coefficient_row_store i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind), .var_id(var_id),
    .operand_value(operand_value), .epsilon_wr(epsilon_wr), .epsilon(epsilon),
    .done(done), .value_out(value_out), .status(status), .entry_total(entry_total)
  );

  // result beats are taken at the edge ending their cycle; watchdog counts silent cycles
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(value_out, status, 7'(entry_total));
      if (done || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) timed_out = 1;
    end
  end

  // issue one command beat, with a random idle gap before it per the phase;
  // start stays high after acceptance unless an idle gap follows
  task automatic issue(logic [2:0] k, logic [15:0] id, logic signed [31:0] v);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    kind <= k;
    var_id <= id;
    operand_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(k, id, v);
    sent++;
  endtask

  // wait for all results plus the tail of a possibly still running command
  task automatic drain();
    start <= 0;
    while (sb.pending.size() != 0 && !timed_out) @(posedge clk);
    repeat (40) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_epsilon(logic [15:0] e);
    drain();
    epsilon_wr <= 1;
    epsilon <= e;
    @(posedge clk);
    epsilon_wr <= 0;
    sb.eps = e;
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(7))
      0: return $urandom_range(200) - 100;
      1: return 32'sh7fffffff - $urandom_range(3);
      2: return 32'sh80000000 + $urandom_range(3);
      3: return 32'($urandom_range(16)) << 16;
      default: return $urandom;
    endcase
  endfunction

  // mostly a small id pool so entries get found again
  function automatic logic [15:0] pick_id();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(7)) * 16'd64 + 16'($urandom_range(3));
      default: return 16'($urandom_range(90));
    endcase
  endfunction

  task automatic random_burst(int n);
    int r;
    logic [2:0] k;
    for (int i = 0; i < n && !timed_out; i++) begin
      r = $urandom_range(99);
      if (r < 30) k = KIND_PUT;
      else if (r < 50) k = KIND_ADD;
      else if (r < 65) k = KIND_REMOVE;
      else if (r < 85) k = KIND_GET;
      else if (r < 90) k = KIND_NEGATE;
      else if (r < 95) k = KIND_DIVIDE;
      else if (r < 97) k = KIND_CLEAR;
      else k = KIND_NONE;
      // divisors mostly kept near one so values survive
      if (k == KIND_DIVIDE && $urandom_range(3) != 0)
        issue(k, pick_id(), 32'sh10000 + $urandom_range(4096) - 2048);
      else issue(k, pick_id(), pick_value());
    end
  endtask

  initial begin
    sb = new();
    sb.clear_row();
    sb.eps = 66;
    idle_pct = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: each kind, field extremes, epsilon edges, full store, zero divisor
    issue(KIND_GET, 16'd5, 0);
    issue(KIND_PUT, 16'hffff, 32'sh7fffffff);
    issue(KIND_PUT, 16'd0, 32'sh80000000);
    issue(KIND_PUT, 16'd64, 32'sd65);
    issue(KIND_PUT, 16'd64, 32'sd66);
    issue(KIND_ADD, 16'hffff, 32'sd100);
    issue(KIND_ADD, 16'd64, -32'sd66);
    issue(KIND_NEGATE, 0, 0);
    issue(KIND_GET, 16'd0, 0);
    issue(KIND_DIVIDE, 0, 0);
    issue(KIND_DIVIDE, 0, 32'sh8000);
    issue(KIND_DIVIDE, 0, -32'sh1);
    issue(KIND_REMOVE, 16'hffff, 0);
    issue(KIND_REMOVE, 16'hffff, 0);
    issue(KIND_NONE, 16'hffff, 32'shffffffff);
    for (int i = 0; i < 66; i++) issue(KIND_PUT, 16'(i * 37), 32'sh10000 + i);
    issue(KIND_ADD, 16'd9999, 32'sh20000);
    issue(KIND_CLEAR, 0, 0);

    set_epsilon(16'd0);
    idle_pct = 85;
    random_burst(300);
    set_epsilon(16'hffff);
    idle_pct = 0;
    random_burst(300);
    set_epsilon(16'($urandom_range(1, 65534)));
    idle_pct = 26;
    random_burst(300);
    set_epsilon(16'd66);
    idle_pct = 0;
    // fill toward capacity so refusals show up in the random part too
    for (int i = 0; i < 64; i++) issue(KIND_PUT, 16'($urandom), 32'sh30000);
    random_burst(300);

    drain();
    if (timed_out) $display("CHECK FAILED");
    else begin
      $display("ran %0d commands over four epsilon settings, %0d result beats checked",
               sent, sb.checked);
      if (sb.mismatches == 0 && sb.pending.size() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
    end
    $finish;
  end

  // timeout path
  initial begin
    wait (timed_out);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: files.f
hdl/srs_pkg.sv
hdl/srs_slot_ram.sv
hdl/srs_divider.sv
hdl/sparse_coefficient_row_store.sv
tb/sv/sparse_coefficient_row_store_test.sv
